FILE: rtl/mntcg_pkg.sv
// Package for the MIDI note to CV/gate converter.
// Holds the request/result structs, the event codes, the controller states and the
// command/status structs shared by the controller and the datapath. Depends on nothing.
`timescale 1ns / 1ps

package mntcg_pkg;

  // Action codes of a request
  localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [1:0] ACT_MODE     = 2'd2;

  // Pitch constants, in semitones
  localparam logic [7:0] NOTE_REF  = 8'd60;
  localparam logic [7:0] OCTAVE_UP = 8'd12;
  localparam logic [7:0] NOTE_MAX  = 8'd127;

  // Gate colour codes
  localparam logic [2:0] COL_BLACK  = 3'd0;
  localparam logic [2:0] COL_BLUE   = 3'd1;
  localparam logic [2:0] COL_CYAN   = 3'd2;
  localparam logic [2:0] COL_ORANGE = 3'd3;
  localparam logic [2:0] COL_RED    = 3'd4;

  typedef enum logic [1:0] {
    EV_APPLIED  = 2'd0,
    EV_HELD     = 2'd1,
    EV_FULL     = 2'd2,
    EV_NOT_HELD = 2'd3
  } evt_status_e;

  typedef enum logic [1:0] {
    K_NOTE_ON,
    K_NOTE_OFF,
    K_MODE,
    K_NONE
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_SHIFT,
    ST_APPLY,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] note;
    logic [6:0] velocity;
  } in_t;

  typedef struct packed {
    logic              gate_on;
    logic signed [7:0] cv_semitones;
    logic [2:0]        led_colour;
    logic              synth_mode;
    logic [1:0]        event_status;
    logic [4:0]        notes_held;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic        load;
    logic        walk;
    logic        shift_wr;
    logic        apply_on;
    logic        apply_off;
    logic        apply_mode;
    logic        report;
    evt_status_e status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  hit;
    logic  walk_end;
    logic  full;
  } sts_t;

  // Map a played note to its gate colour
  function automatic logic [2:0] colour_of(input logic [6:0] n);
    logic [2:0] c;
    c = COL_BLACK;
    if (n inside {[7'd60:7'd63]}) c = COL_BLUE;
    else if (n inside {[7'd64:7'd67]}) c = COL_CYAN;
    else if (n inside {[7'd68:7'd71]}) c = COL_ORANGE;
    else if (n inside {[7'd72:7'd75]}) c = COL_RED;
    return c;
  endfunction

  // Semitones from C4, one octave up and saturated in synth mode
  function automatic logic [7:0] pitch_of(input logic [6:0] n, input logic synth);
    logic [7:0] shifted;
    shifted = {1'b0, n};
    if (synth) begin
      shifted = shifted + OCTAVE_UP;
      if (shifted > NOTE_MAX) shifted = NOTE_MAX;
    end
    return shifted - NOTE_REF;
  endfunction

endpackage

FILE: rtl/mntcg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the held-note table. Depends on nothing.
`timescale 1ns / 1ps

module mntcg_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mntcg_ctrl.sv
// Controller of the MIDI note to CV/gate converter.
// Sequences decode, table search, table close-up, state update and report.
// Depends on mntcg_pkg.
`timescale 1ns / 1ps

module mntcg_ctrl
  import mntcg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e      state_q, state_d;
  evt_status_e stat_q, stat_d;

  // Hold state and pending status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stat_q  <= EV_APPLIED;
    end else begin
      state_q <= state_d;
      stat_q  <= stat_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    stat_d  = stat_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_DECODE;
          stat_d  = EV_APPLIED;
        end
      end
      ST_DECODE: begin
        case (sts_i.kind)
          K_NOTE_ON, K_NOTE_OFF: state_d = ST_SEARCH;
          K_MODE:                state_d = ST_APPLY;
          default:               state_d = ST_REPORT;
        endcase
      end
      ST_SEARCH: begin
        if (sts_i.hit) begin
          if (sts_i.kind == K_NOTE_ON) begin
            stat_d  = EV_HELD;
            state_d = ST_REPORT;
          end else begin
            state_d = ST_SHIFT;
          end
        end else if (sts_i.walk_end) begin
          if (sts_i.kind == K_NOTE_OFF) begin
            stat_d  = EV_NOT_HELD;
            state_d = ST_REPORT;
          end else if (sts_i.full) begin
            stat_d  = EV_FULL;
            state_d = ST_REPORT;
          end else begin
            state_d = ST_APPLY;
          end
        end
      end
      ST_SHIFT: begin
        if (sts_i.walk_end) state_d = ST_APPLY;
      end
      ST_APPLY:  state_d = ST_REPORT;
      ST_REPORT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.status = stat_q;
    busy         = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE:   cmd_o.load = start;
      ST_DECODE: ;
      ST_SEARCH: cmd_o.walk = 1'b1;
      ST_SHIFT: begin
        cmd_o.walk     = 1'b1;
        cmd_o.shift_wr = 1'b1;
      end
      ST_APPLY: begin
        cmd_o.apply_on   = (sts_i.kind == K_NOTE_ON);
        cmd_o.apply_off  = (sts_i.kind == K_NOTE_OFF);
        cmd_o.apply_mode = (sts_i.kind == K_MODE);
      end
      ST_REPORT: cmd_o.report = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/mntcg_dp.sv
// Datapath of the MIDI note to CV/gate converter.
// Holds the request, the held-note table (in mntcg_ram), the walk pointers, the pitch,
// gate, colour and mode state, and the result register. Depends on mntcg_pkg, mntcg_ram.
`timescale 1ns / 1ps

module mntcg_dp
  import mntcg_pkg::*;
#(
  parameter int HELD_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  evt_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic done_o,
  output out_t res_o
);

  localparam int TW = $clog2(HELD_DEPTH + 1);
  localparam int AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;

  in_t           evt_q;
  kind_e         kind_q, kind_d;
  logic [TW-1:0] idx_q, idx_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [TW-1:0] total_q, total_d;
  logic [6:0]    latest_note_q, latest_note_d;
  logic          latest_valid_q, latest_valid_d;
  logic [2:0]    latest_colour_q, latest_colour_d;
  logic          mode_q, mode_d;
  logic          gate_q, gate_d;
  logic [7:0]    cv_q, cv_d;
  logic          done_q;
  out_t          res_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [6:0]    mem_wdata;
  logic [6:0]    mem_rdata;

  mntcg_ram #(
    .WIDTH (7),
    .DEPTH (HELD_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // Decode the request kind
  always_comb begin
    case (evt_i.action)
      ACT_NOTE_ON:  kind_d = (evt_i.velocity != 7'd0) ? K_NOTE_ON : K_NOTE_OFF;
      ACT_NOTE_OFF: kind_d = K_NOTE_OFF;
      ACT_MODE:     kind_d = K_MODE;
      default:      kind_d = K_NONE;
    endcase
  end

  // Walk the table one entry per cycle: issue a read, compare in the next cycle
  always_comb begin
    idx_d    = idx_q;
    rd_vld_d = 1'b0;
    rd_idx_d = rd_idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.walk && (idx_q < total_q)) begin
      idx_d    = TW'(idx_q + 1'b1);
      rd_vld_d = 1'b1;
      rd_idx_d = idx_q[AW-1:0];
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.hit      = rd_vld_q && (mem_rdata == evt_q.note);
  assign sts_o.walk_end = !rd_vld_q && (idx_q >= total_q);
  assign sts_o.full     = (total_q >= TW'(HELD_DEPTH));

  // Table write: append on note-on, move an entry down one place while closing up
  always_comb begin
    mem_we    = cmd_i.apply_on || (cmd_i.shift_wr && rd_vld_q);
    mem_waddr = cmd_i.apply_on ? total_q[AW-1:0] : AW'(rd_idx_q - 1'b1);
    mem_wdata = cmd_i.apply_on ? evt_q.note : mem_rdata;
  end

  // State update
  always_comb begin
    total_d         = total_q;
    latest_note_d   = latest_note_q;
    latest_valid_d  = latest_valid_q;
    latest_colour_d = latest_colour_q;
    mode_d          = mode_q;
    gate_d          = gate_q;
    cv_d            = cv_q;
    if (cmd_i.apply_on) begin
      total_d         = TW'(total_q + 1'b1);
      latest_note_d   = evt_q.note;
      latest_valid_d  = 1'b1;
      latest_colour_d = colour_of(evt_q.note);
      cv_d            = pitch_of(evt_q.note, mode_q);
      gate_d          = 1'b1;
    end else if (cmd_i.apply_off) begin
      total_d = TW'(total_q - 1'b1);
      if (total_q == TW'(1)) gate_d = 1'b0;
    end else if (cmd_i.apply_mode) begin
      mode_d = !mode_q;
      if ((total_q != '0) && latest_valid_q) begin
        cv_d   = pitch_of(latest_note_q, !mode_q);
        gate_d = 1'b1;
      end else begin
        gate_d = 1'b0;
      end
    end
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q        <= 1'b0;
      idx_q           <= '0;
      total_q         <= '0;
      latest_note_q   <= '0;
      latest_valid_q  <= 1'b0;
      latest_colour_q <= COL_BLACK;
      mode_q          <= 1'b0;
      gate_q          <= 1'b0;
      cv_q            <= '0;
      done_q          <= 1'b0;
    end else begin
      rd_vld_q        <= rd_vld_d;
      idx_q           <= idx_d;
      total_q         <= total_d;
      latest_note_q   <= latest_note_d;
      latest_valid_q  <= latest_valid_d;
      latest_colour_q <= latest_colour_d;
      mode_q          <= mode_d;
      gate_q          <= gate_d;
      cv_q            <= cv_d;
      done_q          <= cmd_i.report;
    end
  end

  // Payload: request capture, walk address, result
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    if (cmd_i.load) begin
      evt_q  <= evt_i;
      kind_q <= kind_d;
    end
    if (cmd_i.report) begin
      res_q.gate_on      <= gate_q;
      res_q.cv_semitones <= cv_q;
      res_q.led_colour   <= ((total_q != '0) && latest_valid_q) ? latest_colour_q : COL_BLACK;
      res_q.synth_mode   <= mode_q;
      res_q.event_status <= cmd_i.status;
      res_q.notes_held   <= total_q[4:0];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: rtl/midi_note_to_cv_gate.sv
// Top level of the MIDI note to CV/gate converter.
// Joins the controller (mntcg_ctrl) and the datapath (mntcg_dp). Depends on mntcg_pkg, mntcg_ctrl, mntcg_dp.
//
//   channel   ports                 handshake
//   request   evt_i, start, busy    taken at a clock edge with start high, busy low
//   result    res_o, done_o         valid for the one cycle done_o is high
//
// Note events walk the held-note table one entry per cycle through the single read port
// of the table RAM, so the time a note-on or note-off takes grows with the number of
// notes held; a button press and the unused action code skip the walk.
// busy stays high until the result is reported; one request is in flight at a time.
// Reset clears all control and pitch/gate state; the table needs no clearing pass,
// since only entries below the held count are ever read.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module midi_note_to_cv_gate
  import mntcg_pkg::*;
#(
  parameter int HELD_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  evt_i,
  output logic done_o,
  output out_t res_o
);

  cmd_t cmd;
  sts_t sts;

  mntcg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  mntcg_dp #(
    .HELD_DEPTH (HELD_DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // An accepted request keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // A result strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // The gate is open exactly while notes are held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (HELD_DEPTH < 32) |-> res_o.gate_on == (res_o.notes_held != 5'd0))
    else $error("gate does not follow the held-note count");

  // A colour shows only while the gate is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.led_colour != COL_BLACK) |-> res_o.gate_on)
    else $error("colour shown with the gate closed");

endmodule

FILE: tb/midi_note_to_cv_gate_test.sv
// Self-checking test of the MIDI note to CV/gate converter (midi_note_to_cv_gate).
// A queue-fed request driver, a result monitor and a cycle-free note table model that
// predicts each result at request acceptance. Depends on mntcg_pkg and the RTL.
`timescale 1ns / 1ps

module midi_note_to_cv_gate_test;
  import mntcg_pkg::*;

  localparam int          TABLE_DEPTH  = 16;
  localparam int          RANDOM_COUNT = 950;
  localparam int          SETTLE_TICKS = 2 * TABLE_DEPTH + 20;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  in_t  evt_i  = '0;
  logic busy;
  logic done_o;
  out_t res_o;

  midi_note_to_cv_gate #(
    .HELD_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .evt_i (evt_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  always #2 clk_i = ~clk_i;

  // Note table model state
  logic [6:0] held_notes [TABLE_DEPTH];
  int         held_count  = 0;
  logic [6:0] last_note   = '0;
  logic       last_valid  = 1'b0;
  logic [2:0] last_colour = COL_BLACK;
  logic       synth_on    = 1'b0;
  logic       gate_open   = 1'b0;
  logic [7:0] cv_value    = '0;

  in_t  midi_events_q [$];
  out_t cv_gate_due_q [$];
  logic [6:0] gen_held [$];   // notes the stimulus believes are held

  int events_queued   = 0;
  int events_taken    = 0;
  int counted_events  = 0;
  int mismatch_count  = 0;
  int gap_left        = 0;
  int calm_left       = 0;

  // Colour band of a played note: four notes per band from C4 up
  function automatic logic [2:0] note_colour(input logic [6:0] n);
    if (n < 7'd60 || n > 7'd75) return COL_BLACK;
    return 3'((n - 7'd60) >> 2) + 3'd1;
  endfunction

  // Semitones from C4, octave up with saturation in synth mode
  function automatic logic [7:0] note_to_cv(input logic [6:0] n);
    logic [7:0] wide;
    wide = {1'b0, n};
    if (synth_on) wide = (n >= 7'd115) ? 8'd127 : wide + 8'd12;
    return wide - 8'd60;
  endfunction

  function automatic int table_index(input logic [6:0] n);
    for (int i = 0; i < held_count; i++) begin
      if (held_notes[i] == n) return i;
    end
    return -1;
  endfunction

  // Apply one MIDI event to the note table and return the resulting CV/gate report
  function automatic out_t apply_midi_event(input in_t ev);
    out_t        r;
    evt_status_e st;
    int          pos;
    st  = EV_APPLIED;
    pos = table_index(ev.note);
    if (ev.action == ACT_NOTE_ON && ev.velocity != 7'd0) begin
      if (pos >= 0) st = EV_HELD;
      else if (held_count >= TABLE_DEPTH) st = EV_FULL;
      else begin
        held_notes[held_count] = ev.note;
        held_count++;
        last_note   = ev.note;
        last_valid  = 1'b1;
        last_colour = note_colour(ev.note);
        cv_value    = note_to_cv(ev.note);
        gate_open   = 1'b1;
      end
    end else if (ev.action == ACT_NOTE_ON || ev.action == ACT_NOTE_OFF) begin
      if (pos < 0) st = EV_NOT_HELD;
      else begin
        for (int j = pos + 1; j < held_count; j++) held_notes[j - 1] = held_notes[j];
        held_count--;
        held_notes[held_count] = '0;
        if (held_count == 0) gate_open = 1'b0;
      end
    end else if (ev.action == ACT_MODE) begin
      synth_on = ~synth_on;
      if (held_count > 0 && last_valid) begin
        cv_value  = note_to_cv(last_note);
        gate_open = 1'b1;
      end else begin
        gate_open = 1'b0;
      end
    end
    r.gate_on      = gate_open;
    r.cv_semitones = cv_value;
    r.led_colour   = (held_count != 0 && last_valid) ? last_colour : COL_BLACK;
    r.synth_mode   = synth_on;
    r.event_status = st;
    r.notes_held   = 5'(held_count);
    return r;
  endfunction

  // Request gap: mostly none or short, a few long, with calm stretches
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm_left = $urandom_range(20, 100);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Queue one request and track which notes it leaves held
  task automatic add_event(input logic [1:0] act, input logic [6:0] n, input logic [6:0] vel);
    in_t ev;
    int  idx;
    ev.action   = act;
    ev.note     = n;
    ev.velocity = vel;
    midi_events_q.push_back(ev);
    events_queued++;
    if (act != ACT_UNUSED) counted_events++;
    idx = -1;
    foreach (gen_held[i]) if (gen_held[i] == n) idx = i;
    if (act == ACT_NOTE_ON && vel != 7'd0) begin
      if (idx < 0 && gen_held.size() < TABLE_DEPTH) gen_held.push_back(n);
    end else if (act == ACT_NOTE_ON || act == ACT_NOTE_OFF) begin
      if (idx >= 0) gen_held.delete(idx);
    end
  endtask

  function automatic logic [6:0] pick_note();
    if ($urandom_range(0, 9) < 7) return 7'($urandom_range(52, 83));
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic release_one();
    logic [6:0] n;
    n = gen_held[$urandom_range(0, gen_held.size() - 1)];
    if ($urandom_range(0, 3) == 0) add_event(ACT_NOTE_ON, n, 7'd0);
    else add_event(ACT_NOTE_OFF, n, 7'($urandom_range(0, 127)));
  endtask

  // Build a chord, maybe overfill it, flip mode now and then, then release
  task automatic play_chord();
    int target;
    int keep;
    target = ($urandom_range(0, 3) == 0) ? TABLE_DEPTH : $urandom_range(1, 8);
    while (gen_held.size() < target) begin
      add_event(ACT_NOTE_ON, pick_note(), 7'($urandom_range(1, 127)));
      if ($urandom_range(0, 19) == 0) add_event(ACT_MODE, pick_note(), 7'($urandom_range(0, 127)));
    end
    if (target == TABLE_DEPTH) begin
      repeat ($urandom_range(1, 3)) add_event(ACT_NOTE_ON, pick_note(), 7'($urandom_range(1, 127)));
    end
    if ($urandom_range(0, 2) == 0) add_event(ACT_MODE, pick_note(), 7'($urandom_range(0, 127)));
    keep = ($urandom_range(0, 2) == 0) ? $urandom_range(0, gen_held.size()) : 0;
    while (gen_held.size() > keep) release_one();
  endtask

  task automatic random_single();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) add_event(ACT_NOTE_ON, pick_note(), 7'($urandom_range(1, 127)));
    else if (sel < 50) add_event(ACT_NOTE_ON, 7'($urandom_range(0, 127)), 7'd0);
    else if (sel < 65) add_event(ACT_NOTE_OFF, 7'($urandom_range(0, 127)),
                                 7'($urandom_range(0, 127)));
    else if (sel < 82 && gen_held.size() > 0) release_one();
    else if (sel < 95) add_event(ACT_MODE, 7'($urandom_range(0, 127)),
                                 7'($urandom_range(0, 127)));
    else add_event(ACT_UNUSED, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
  endtask

  // Drive requests; predict each one at the edge that accepts it
  always @(posedge clk_i) begin : drive_requests
    logic take_next;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && busy === 1'b0) begin
        cv_gate_due_q.push_back(apply_midi_event(evt_i));
        events_taken++;
      end
      take_next = !start || busy === 1'b0;
      if (take_next) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (midi_events_q.size() > 0) begin
          evt_i    <= midi_events_q.pop_front();
          start    <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string field, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  // Check every reported result against the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (cv_gate_due_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none actual %h", $time, res_o);
        mismatch_count++;
      end else begin
        want = cv_gate_due_q.pop_front();
        if (res_o.gate_on !== want.gate_on)
          report_field("gate_on", want.gate_on, res_o.gate_on);
        if (res_o.cv_semitones !== want.cv_semitones)
          report_field("cv_semitones", want.cv_semitones, res_o.cv_semitones);
        if (res_o.led_colour !== want.led_colour)
          report_field("led_colour", want.led_colour, res_o.led_colour);
        if (res_o.synth_mode !== want.synth_mode)
          report_field("synth_mode", want.synth_mode, res_o.synth_mode);
        if (res_o.event_status !== want.event_status)
          report_field("event_status", want.event_status, res_o.event_status);
        if (res_o.notes_held !== want.notes_held)
          report_field("notes_held", want.notes_held, res_o.notes_held);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int target_count;
    // Mode presses with an empty table, then a release of a note never held
    add_event(ACT_MODE, 7'd0, 7'd0);
    add_event(ACT_MODE, 7'd127, 7'd127);
    add_event(ACT_NOTE_OFF, 7'd60, 7'd64);
    // Extremes of note and velocity, then a duplicate
    add_event(ACT_NOTE_ON, 7'd0, 7'd127);
    add_event(ACT_NOTE_ON, 7'd127, 7'd1);
    add_event(ACT_NOTE_ON, 7'd127, 7'd100);
    // Synth mode with notes held: saturate at the top
    add_event(ACT_MODE, 7'd33, 7'd85);
    add_event(ACT_NOTE_ON, 7'd60, 7'd64);
    add_event(ACT_NOTE_ON, 7'd115, 7'd42);
    add_event(ACT_NOTE_ON, 7'd116, 7'd21);
    // Release under other held notes, then an unused action code
    add_event(ACT_NOTE_OFF, 7'd127, 7'd0);
    add_event(ACT_UNUSED, 7'd5, 7'd5);
    // Colour band edges
    add_event(ACT_NOTE_ON, 7'd63, 7'd10);
    add_event(ACT_NOTE_ON, 7'd64, 7'd20);
    add_event(ACT_NOTE_ON, 7'd67, 7'd30);
    add_event(ACT_NOTE_ON, 7'd68, 7'd40);
    add_event(ACT_NOTE_ON, 7'd71, 7'd50);
    add_event(ACT_NOTE_ON, 7'd72, 7'd60);
    add_event(ACT_NOTE_ON, 7'd75, 7'd70);
    add_event(ACT_NOTE_ON, 7'd76, 7'd80);
    add_event(ACT_NOTE_ON, 7'd59, 7'd90);
    // Back to normal mode, note-on with zero velocity as release, fill and overflow
    add_event(ACT_MODE, 7'd1, 7'd2);
    add_event(ACT_NOTE_ON, 7'd60, 7'd0);
    for (int n = 100; n < 105; n++) add_event(ACT_NOTE_ON, 7'(n), 7'd99);

    target_count = counted_events + RANDOM_COUNT;
    while (counted_events < target_count) begin
      if ($urandom_range(0, 99) < 35) play_chord();
      else random_single();
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (events_taken < events_queued || cv_gate_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
